@@ sv/assert_macros.svh @@
// Assertion macros for the paired station table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PST_ASSERT(lbl, clk, rst_n, prop, msg)
`define PST_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ sv/pst_pkg.sv @@
// Types and constants shared by the paired station table modules.
`default_nettype none
package pst_pkg;
    localparam int ADDR_W = 48;
    localparam int MASK_W = 8;
    localparam int SLOT_W = 3;
    localparam int STS_W  = 3;
    localparam int OP_W   = 2;

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_DEL   = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

    localparam logic [STS_W-1:0] STS_NONE     = 3'd0;
    localparam logic [STS_W-1:0] STS_STORED   = 3'd1;
    localparam logic [STS_W-1:0] STS_REPLACED = 3'd2;
    localparam logic [STS_W-1:0] STS_REMOVED  = 3'd3;
    localparam logic [STS_W-1:0] STS_FULL     = 3'd4;

    localparam logic CFG_STATION_MODE = 1'b0;
    localparam logic CFG_PAIRED_ONLY  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_stat;
endpackage
`default_nettype wire

@@ sv/paired_station_table_top.sv @@
// Top level of the paired station table: config registers, sequencer, datapath.
// One event is taken when start is high and busy is low. The table is scanned
// one slot per cycle through a single registered memory read port. After the
// last slot the sequencer passes through drain and decide back to idle. The
// result shows for exactly one cycle with o_done high, in the cycle where busy
// has dropped again; the receiver cannot stall it, so it must capture the
// result in that cycle. Configuration writes take effect at once and belong
// only where the block is idle.
`default_nettype none
`include "assert_macros.svh"
module paired_station_table_top import pst_pkg::*; #(
    parameter int NUM_STATIONS = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [ADDR_W-1:0] i_mac,
    input  wire logic [MASK_W-1:0] i_connected_mask,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic              i_cfg_data,
    output logic                   o_done,
    output logic                   o_reject,
    output logic [STS_W-1:0]       o_status,
    output logic [SLOT_W-1:0]      o_slot
);
    logic  r_station_mode;
    logic  r_paired_only;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_mode <= 1'b0;
            r_paired_only  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STATION_MODE: r_station_mode <= i_cfg_data;
                CFG_PAIRED_ONLY:  r_paired_only  <= i_cfg_data;
                default:          r_paired_only  <= r_paired_only;
            endcase
        end
    end

    pst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (w_busy)
    );

    pst_dp #(
        .NUM_STATIONS (NUM_STATIONS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_op           (i_op),
        .i_mac          (i_mac),
        .i_mask         (i_connected_mask),
        .i_station_mode (r_station_mode),
        .i_paired_only  (r_paired_only),
        .o_done         (o_done),
        .o_reject       (o_reject),
        .o_status       (o_status),
        .o_slot         (o_slot)
    );

    assign busy = w_busy;

    `PST_ASSERT(a_done_when_idle, i_clk, i_rst_n, o_done |-> !busy, "result while busy")
    `PST_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "transfer not taken")
    `PST_ASSERT(a_reject_quiet, i_clk, i_rst_n, (o_done && o_reject) |-> (o_status == STS_NONE && o_slot == '0), "reject with table change")
    `PST_ASSERT(a_noop_slot, i_clk, i_rst_n, (o_done && (o_status == STS_NONE || o_status == STS_FULL)) |-> (o_slot == '0), "slot set without change")
endmodule
`default_nettype wire

@@ sv/pst_ctrl.sv @@
// Sequencer for the paired station table: load, scan, drain, decide.
`default_nettype none
module pst_ctrl import pst_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.last) n_state = S_DRAIN;
            end
            S_DRAIN:  n_state = S_DECIDE;
            S_DECIDE: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_SCAN:   o_cmd.scan = 1'b1;
            S_DRAIN:  o_cmd = '0;
            S_DECIDE: o_cmd.decide = 1'b1;
            default:  o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

@@ sv/pst_dp.sv @@
// Datapath: station table memory, slot scan, first-hit tracking and update.
`default_nettype none
module pst_dp import pst_pkg::*; #(
    parameter int NUM_STATIONS = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_stat                  o_stat,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [ADDR_W-1:0] i_mac,
    input  wire logic [MASK_W-1:0] i_mask,
    input  wire logic              i_station_mode,
    input  wire logic              i_paired_only,
    output logic                   o_done,
    output logic                   o_reject,
    output logic [STS_W-1:0]       o_status,
    output logic [SLOT_W-1:0]      o_slot
);
    localparam int IDX_W = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_STATIONS - 1);

    logic [ADDR_W-1:0] mem [NUM_STATIONS];
    logic [NUM_STATIONS-1:0] r_vld;

    logic [OP_W-1:0]   r_op;
    logic [ADDR_W-1:0] r_mac;
    logic [MASK_W-1:0] r_mask;
    logic [IDX_W-1:0]  r_idx;
    logic              r_pipe_vld;
    logic [IDX_W-1:0]  r_pipe_idx;
    logic [ADDR_W-1:0] r_rd_data;
    logic              r_rd_live;
    logic              r_hit, r_emp, r_dis;
    logic [IDX_W-1:0]  r_hit_idx, r_emp_idx, r_dis_idx;
    logic [ADDR_W-1:0] r_e0;
    logic              r_done;
    logic              r_reject;
    logic [STS_W-1:0]  r_status;
    logic [SLOT_W-1:0] r_slot;

    logic [ADDR_W-1:0] w_entry;
    logic [2:0]        w_lo;
    logic              w_match, w_empty, w_disc;
    logic              w_we;
    logic [IDX_W-1:0]  w_widx;
    logic [ADDR_W-1:0] w_wdata;
    logic              w_reject;
    logic [STS_W-1:0]  w_status;

    assign o_stat.last = (r_idx == LAST_IDX);

    // never-written slots read as empty
    assign w_entry = r_rd_live ? r_rd_data : '0;
    assign w_lo    = 3'(r_pipe_idx);
    assign w_match = (w_entry == r_mac);
    assign w_empty = (w_entry == '0);
    // slots past the mask width count as connected
    assign w_disc  = (32'(r_pipe_idx) < 32'd8) && !r_mask[w_lo];

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_rd_data <= mem[r_idx];
        end
        if (w_we) begin
            mem[w_widx] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_mac  <= i_mac;
            r_mask <= i_mask;
        end
        if (r_pipe_vld && r_pipe_idx == '0) begin
            r_e0 <= w_entry;
        end
        if (r_pipe_vld && w_match && !r_hit) r_hit_idx <= r_pipe_idx;
        if (r_pipe_vld && w_empty && !r_emp) r_emp_idx <= r_pipe_idx;
        if (r_pipe_vld && w_disc && !r_dis)  r_dis_idx <= r_pipe_idx;
        if (i_cmd.scan) begin
            r_pipe_idx <= r_idx;
        end
        if (i_cmd.decide) begin
            r_reject <= w_reject;
            r_status <= w_status;
            r_slot   <= w_we ? SLOT_W'(w_widx) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_idx      <= '0;
            r_pipe_vld <= 1'b0;
            r_rd_live  <= 1'b0;
            r_hit      <= 1'b0;
            r_emp      <= 1'b0;
            r_dis      <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_pipe_vld <= i_cmd.scan;
            r_done     <= i_cmd.decide;
            if (i_cmd.scan) begin
                r_rd_live <= r_vld[r_idx];
                r_idx     <= r_idx + 1'b1;
            end
            if (i_cmd.load) begin
                r_idx <= '0;
                r_hit <= 1'b0;
                r_emp <= 1'b0;
                r_dis <= 1'b0;
            end else if (r_pipe_vld) begin
                if (w_match) r_hit <= 1'b1;
                if (w_empty) r_emp <= 1'b1;
                if (w_disc)  r_dis <= 1'b1;
            end
            if (w_we) begin
                r_vld[w_widx] <= 1'b1;
            end
        end
    end

    always_comb begin
        w_we     = 1'b0;
        w_widx   = '0;
        w_wdata  = r_mac;
        w_reject = 1'b0;
        w_status = STS_NONE;
        unique case (r_op)
            OP_CHECK: begin
                w_reject = i_paired_only && !r_hit;
            end
            OP_ADD: begin
                if (i_station_mode) begin
                    if (r_e0 != r_mac) begin
                        w_we = 1'b1;
                        priority if (r_mac == '0) w_status = STS_REMOVED;
                        else if (r_e0 == '0)      w_status = STS_STORED;
                        else                      w_status = STS_REPLACED;
                    end
                end else if (!r_hit) begin
                    priority if (r_emp) begin
                        w_we     = 1'b1;
                        w_widx   = r_emp_idx;
                        w_status = STS_STORED;
                    end else if (r_dis) begin
                        w_we     = 1'b1;
                        w_widx   = r_dis_idx;
                        w_status = STS_REPLACED;
                    end else begin
                        w_status = STS_FULL;
                    end
                end
            end
            OP_DEL: begin
                w_wdata = '0;
                if (i_station_mode) begin
                    if (r_mac != '0 && r_e0 == r_mac) begin
                        w_we     = 1'b1;
                        w_status = STS_REMOVED;
                    end
                end else if (r_mac != '0 && r_hit) begin
                    w_we     = 1'b1;
                    w_widx   = r_hit_idx;
                    w_status = STS_REMOVED;
                end
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
        w_we = w_we && i_cmd.decide;
    end

    assign o_done   = r_done;
    assign o_reject = r_reject;
    assign o_status = r_status;
    assign o_slot   = r_slot;
endmodule
`default_nettype wire
